FILE: hdl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  // Table depth default
  localparam int DefMaxPoints = 64;

  // Field widths
  localparam int DataW  = 32;
  localparam int SlotW  = 6;
  localparam int SegW   = 6;
  localparam int CountW = 7;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;

  // Division length: one quotient bit per cycle over the 64-bit product
  localparam int ProdW = 2 * DataW;
  localparam int DivCntW = 6;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_EXTRAPOLATE = 1'b1;

  // Reset value of point count
  localparam logic [CountW-1:0] PointCountRst = 7'd2;

  // Saturation limits
  localparam logic signed [DataW-1:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] S32Min = 32'sh8000_0000;

  // Query sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_SEARCH,
    ST_RD_L,
    ST_RD_R,
    ST_PREP,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table in two memories, segment search and Q16.16 line value.
// ----------------------------------------------------------------------------
// A load word writes one breakpoint into the x and y memories. A query word
// holds off the input until its result is handed on. It reads one x per
// searched breakpoint (no search when x is at or above breakpoint
// point_count-2 or when only two points are in use), then the two end points,
// forms the differences, does one 32x32 multiply and runs a restoring divider
// that makes one quotient bit per cycle over the 64-bit product. When a
// difference is zero the divider is skipped. A finished result also waits for
// as long as the previous result word is still held in the output register.
// The result sits in an output register, so the next word is taken while it
// waits. The memories have no reset; a query that reads a slot never loaded
// returns an undefined value.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = pli_pkg::DefMaxPoints
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [pli_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pli_pkg::CfgDataW-1:0]        cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [pli_pkg::SlotW-1:0]           point_index_i,
  input  logic signed [pli_pkg::DataW-1:0]    x_value_i,
  input  logic signed [pli_pkg::DataW-1:0]    y_value_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pli_pkg::DataW-1:0]    y_result_o,
  output logic [pli_pkg::SegW-1:0]            segment_index_o
);
  import pli_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // Configuration registers
  logic [CountW-1:0] pc_q;
  logic              ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PointCountRst;
      ext_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POINT_COUNT: pc_q  <= cfg_data_i;
        CFG_EXTRAPOLATE: ext_q <= cfg_data_i[0];
      endcase
    end
  end

  // Handshake
  state_e state_q, state_d;
  logic   in_acc;
  logic   load_we;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_we    = in_acc && (operation_i == OP_LOAD) &&
                      (32'(point_index_i) < 32'(MAX_POINTS));

  // Breakpoint memories
  logic signed [DataW-1:0] x_mem [MAX_POINTS];
  logic signed [DataW-1:0] y_mem [MAX_POINTS];
  logic        [AW-1:0]    raddr;
  logic signed [DataW-1:0] xrd_q, yrd_q;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      x_mem[AW'(point_index_i)] <= x_value_i;
      y_mem[AW'(point_index_i)] <= y_value_i;
    end
    xrd_q <= x_mem[raddr];
    yrd_q <= y_mem[raddr];
  end

  // Datapath registers
  logic [AW-1:0]           i_q, i_d;
  logic [AW-1:0]           nm2_q, nm2_d;
  logic [DivCntW-1:0]      cnt_q, cnt_d;
  logic signed [DataW-1:0] xv_q, xv_d;
  logic signed [DataW-1:0] xl_q, xl_d, yl_q, yl_d, xr_q, xr_d, yr_q, yr_d;
  logic signed [DataW:0]   dx_q, dx_d, dd_q, dd_d;
  logic [DataW-1:0]        mdx_q, mdx_d, mdy_q, mdy_d, mdd_q, mdd_d;
  logic                    neg_q, neg_d, zero_q, zero_d;
  logic [ProdW-1:0]        quo_q, quo_d;
  logic [DataW-1:0]        rem_q, rem_d;
  logic signed [DataW-1:0] res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] y_result_q, y_result_d;
  logic [SegW-1:0]         seg_q, seg_d;

  // Combinational temporaries
  logic [31:0]             n_w;
  logic [AW-1:0]           nm2_now;
  logic signed [DataW-1:0] yl_t, yr_t;
  logic signed [DataW:0]   dy_t;
  logic [DataW:0]          trial;
  logic                    qbit;
  logic                    big;
  logic signed [DataW+4:0] sum_t;
  logic                    out_free;

  // Effective point count minus two
  always_comb begin
    n_w = 32'(pc_q);
    if (n_w < 32'd2) n_w = 32'd2;
    if (n_w > 32'(MAX_POINTS)) n_w = 32'(MAX_POINTS);
    nm2_now = AW'(n_w - 32'd2);
  end

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    raddr       = i_q;
    i_d         = i_q;
    nm2_d       = nm2_q;
    cnt_d       = cnt_q;
    xv_d        = xv_q;
    xl_d        = xl_q;
    yl_d        = yl_q;
    xr_d        = xr_q;
    yr_d        = yr_q;
    dx_d        = dx_q;
    dd_d        = dd_q;
    mdx_d       = mdx_q;
    mdy_d       = mdy_q;
    mdd_d       = mdd_q;
    neg_d       = neg_q;
    zero_d      = zero_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    res_d       = res_q;
    y_result_d  = y_result_q;
    seg_d       = seg_q;
    yl_t        = yl_q;
    yr_t        = yr_q;
    dy_t        = '0;
    trial       = '0;
    qbit        = 1'b0;
    big         = 1'b0;
    sum_t       = '0;
    out_free    = !out_valid_q || !out_stall_i;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        raddr = nm2_now;
        if (in_acc && (operation_i == OP_QUERY)) begin
          xv_d    = x_value_i;
          nm2_d   = nm2_now;
          i_d     = '0;
          state_d = ST_LAST;
        end
      end
      // x of the last segment's left end
      ST_LAST: begin
        if (xv_q >= xrd_q) begin
          i_d     = nm2_q;
          raddr   = nm2_q;
          state_d = ST_RD_L;
        end else if (nm2_q == '0) begin
          i_d     = '0;
          raddr   = '0;
          state_d = ST_RD_L;
        end else begin
          raddr   = i_q + AW'(1);
          state_d = ST_SEARCH;
        end
      end
      // xrd_q is x[i+1]; move on while the query lies beyond it
      ST_SEARCH: begin
        if (xv_q > xrd_q) begin
          i_d   = i_q + AW'(1);
          raddr = i_q + AW'(2);
        end else begin
          raddr   = i_q;
          state_d = ST_RD_L;
        end
      end
      ST_RD_L: begin
        xl_d    = xrd_q;
        yl_d    = yrd_q;
        raddr   = i_q + AW'(1);
        state_d = ST_RD_R;
      end
      ST_RD_R: begin
        xr_d    = xrd_q;
        yr_d    = yrd_q;
        state_d = ST_PREP;
      end
      // without extrapolation clamp to end values; form x differences
      ST_PREP: begin
        if (!ext_q) begin
          if (xv_q < xl_q) yr_t = yl_t;
          if (xv_q > xr_q) yl_t = yr_t;
        end
        yl_d    = yl_t;
        yr_d    = yr_t;
        dx_d    = {xv_q[DataW-1], xv_q} - {xl_q[DataW-1], xl_q};
        dd_d    = {xr_q[DataW-1], xr_q} - {xl_q[DataW-1], xl_q};
        state_d = ST_DIFF;
      end
      // magnitudes and result sign
      ST_DIFF: begin
        dy_t    = {yr_q[DataW-1], yr_q} - {yl_q[DataW-1], yl_q};
        mdy_d   = dy_t[DataW] ? DataW'((DataW+1)'(0) - dy_t) : dy_t[DataW-1:0];
        mdx_d   = dx_q[DataW] ? DataW'((DataW+1)'(0) - dx_q) : dx_q[DataW-1:0];
        mdd_d   = dd_q[DataW] ? DataW'((DataW+1)'(0) - dd_q) : dd_q[DataW-1:0];
        neg_d   = dy_t[DataW] ^ dx_q[DataW] ^ dd_q[DataW];
        zero_d  = (dy_t == '0) || (dx_q == '0) || (dd_q == '0);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (zero_q) begin
          res_d   = yl_q;
          state_d = ST_OUT;
        end else begin
          quo_d   = ProdW'(mdy_q) * ProdW'(mdx_q);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        trial = {rem_q, quo_q[ProdW-1]};
        qbit  = (trial >= {1'b0, mdd_q});
        rem_d = qbit ? DataW'(trial - {1'b0, mdd_q}) : trial[DataW-1:0];
        quo_d = {quo_q[ProdW-2:0], qbit};
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == {DivCntW{1'b1}}) state_d = ST_FIN;
      end
      // add to left y and saturate
      ST_FIN: begin
        big = (|quo_q[ProdW-1:35]) || (quo_q[34] && (|quo_q[33:0]));
        if (neg_q) sum_t = {{5{yl_q[DataW-1]}}, yl_q} - {2'b00, quo_q[34:0]};
        else       sum_t = {{5{yl_q[DataW-1]}}, yl_q} + {2'b00, quo_q[34:0]};
        if (big) begin
          res_d = neg_q ? S32Min : S32Max;
        end else if (sum_t[DataW+4:DataW-1] != {6{sum_t[DataW+4]}}) begin
          res_d = sum_t[DataW+4] ? S32Min : S32Max;
        end else begin
          res_d = sum_t[DataW-1:0];
        end
        state_d = ST_OUT;
      end
      // hand over to the output register
      ST_OUT: begin
        if (out_free) begin
          y_result_d  = res_q;
          seg_d       = SegW'(i_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    nm2_q      <= nm2_d;
    cnt_q      <= cnt_d;
    xv_q       <= xv_d;
    xl_q       <= xl_d;
    yl_q       <= yl_d;
    xr_q       <= xr_d;
    yr_q       <= yr_d;
    dx_q       <= dx_d;
    dd_q       <= dd_d;
    mdx_q      <= mdx_d;
    mdy_q      <= mdy_d;
    mdd_q      <= mdd_d;
    neg_q      <= neg_d;
    zero_q     <= zero_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    res_q      <= res_d;
    y_result_q <= y_result_d;
    seg_q      <= seg_d;
  end

  assign out_valid_o     = out_valid_q;
  assign y_result_o      = y_result_q;
  assign segment_index_o = seg_q;

endmodule

`default_nettype wire

FILE: hdl/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic signed [pli_pkg::DataW-1:0] y_result_o,
  input  logic [pli_pkg::SegW-1:0]         segment_index_o
);
  import pli_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(y_result_o) &&
                                   $stable(segment_index_o))
    else $error("result word changed while stalled");

  // a load word never yields a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("result after load word");

  // a query occupies the block and its result is not immediate
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_QUERY) |=> in_stall_o && !$rose(out_valid_o))
    else $error("query not held or answered too early");

  // a new result only comes while the input is held off
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query in flight");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .y_result_o      (y_result_o),
  .segment_index_o (segment_index_o)
);

`default_nettype wire

FILE: test/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Loads breakpoint tables through the word port, queries them and checks
// every result word against a cycle-free line model kept in the bench.
// Random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_interpolator;
  import pli_pkg::*;

  localparam int     MaxPts      = DefMaxPoints;
  localparam int     ItemTarget  = 1750;
  localparam int     DrainCycles = 160;
  localparam int     CycleLimit  = 1_500_000;
  localparam int     HoldCycles  = 400;
  localparam longint Span32      = 64'd4294967295;

  typedef struct {
    logic                    op;
    logic [SlotW-1:0]        slot;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
  } word_t;

  typedef struct {
    logic signed [DataW-1:0] y;
    logic [SegW-1:0]         seg;
  } line_result_t;

  // DUT ports
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    operation_i = OP_LOAD;
  logic [SlotW-1:0]        point_index_i = '0;
  logic signed [DataW-1:0] x_value_i = '0;
  logic signed [DataW-1:0] y_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] y_result_o;
  logic [SegW-1:0]         segment_index_o;

  // Bench state
  word_t                   words_to_send[$];
  line_result_t            expected_results[$];
  logic signed [DataW-1:0] bp_x [MaxPts];     // table as the block holds it
  logic signed [DataW-1:0] bp_y [MaxPts];
  logic signed [DataW-1:0] plan_x [MaxPts];   // table as the generator sees it
  logic [CountW-1:0]       cur_count = PointCountRst;
  logic                    cur_extrap = 1'b0;
  int                      items_made = 0;
  int                      words_accepted = 0;
  int                      results_seen = 0;
  int                      mismatches = 0;
  int                      send_idle_pct = 33;
  int                      recv_idle_pct = 68;
  int                      cycles = 0;

  piecewise_linear_interpolator #(
    .MAX_POINTS(MaxPts)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .point_index_i  (point_index_i),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .y_result_o     (y_result_o),
    .segment_index_o(segment_index_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------

  // yl + (yr-yl)*(x-xl)/(xr-xl), product first, truncating divide, saturated
  function automatic logic signed [DataW-1:0] line_through(
    input logic signed [DataW-1:0] xl, input logic signed [DataW-1:0] yl,
    input logic signed [DataW-1:0] xr, input logic signed [DataW-1:0] yr,
    input logic signed [DataW-1:0] x);
    longint          dy;
    longint          dx;
    longint          dd;
    longint unsigned mdy;
    longint unsigned mdx;
    longint unsigned mdd;
    longint unsigned q;
    longint          r;
    bit              neg;
    dy = longint'(yr) - longint'(yl);
    dx = longint'(x) - longint'(xl);
    dd = longint'(xr) - longint'(xl);
    if (dd == 0 || dy == 0 || dx == 0) return yl;
    neg = ((dy < 0) != (dx < 0)) != (dd < 0);
    mdy = (dy < 0) ? -dy : dy;
    mdx = (dx < 0) ? -dx : dx;
    mdd = (dd < 0) ? -dd : dd;
    q = (mdy * mdx) / mdd;
    if (q > (64'd1 << 34)) return neg ? S32Min : S32Max;
    r = neg ? longint'(yl) - longint'(q) : longint'(yl) + longint'(q);
    if (r > longint'(S32Max)) return S32Max;
    if (r < longint'(S32Min)) return S32Min;
    return r[DataW-1:0];
  endfunction

  // segment search plus end clamping
  function automatic line_result_t interpolate_at(input logic signed [DataW-1:0] xq);
    int                      n;
    int                      i;
    logic signed [DataW-1:0] xl, yl, xr, yr;
    line_result_t            res;
    n = int'(cur_count);
    if (n < 2) n = 2;
    if (n > MaxPts) n = MaxPts;
    if (xq >= bp_x[n-2]) begin
      i = n - 2;
    end else begin
      i = 0;
      while (i < n - 2 && xq > bp_x[i+1]) i++;
    end
    xl = bp_x[i];
    yl = bp_y[i];
    xr = bp_x[i+1];
    yr = bp_y[i+1];
    if (!cur_extrap) begin
      if (xq < xl) yr = yl;
      if (xq > xr) yl = yr;
    end
    res.y   = line_through(xl, yl, xr, yr, xq);
    res.seg = i[SegW-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one word in flight, predicted when accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_words
    word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        words_accepted++;
        if (operation_i == OP_LOAD) begin
          bp_x[point_index_i] = x_value_i;
          bp_y[point_index_i] = y_value_i;
        end else begin
          expected_results.insert(expected_results.size(), interpolate_at(x_value_i));
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = words_to_send.pop_front();
          operation_i   <= w.op;
          point_index_i <= w.slot;
          x_value_i     <= w.x;
          y_value_i     <= w.y;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and receiver stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    line_result_t e;
    int           hold_left;
    bit           hold_done;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with none expected: y_result %0d segment_index %0d",
                 y_result_o, segment_index_o);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (y_result_o !== e.y) begin
            $error("y_result: expected %0d, got %0d", e.y, y_result_o);
            mismatches++;
          end
          if (segment_index_o !== e.seg) begin
            $error("segment_index: expected %0d, got %0d", e.seg, segment_index_o);
            mismatches++;
          end
        end
        results_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_seen == 150) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      if (hold_left != 0) hold_left--;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_load(input logic [SlotW-1:0] slot, input logic signed [DataW-1:0] x,
                           input logic signed [DataW-1:0] y);
    word_t w;
    w.op   = OP_LOAD;
    w.slot = slot;
    w.x    = x;
    w.y    = y;
    plan_x[slot] = x;
    words_to_send.insert(words_to_send.size(), w);
    items_made++;
  endtask

  task automatic push_query(input logic signed [DataW-1:0] x);
    word_t w;
    w.op   = OP_QUERY;
    w.slot = 6'($urandom);
    w.x    = x;
    w.y    = $urandom;
    words_to_send.insert(words_to_send.size(), w);
    items_made++;
  endtask

  // wait until every word is taken and answered, then let the block go quiet
  task automatic settle();
    while (words_accepted != items_made || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CFG_POINT_COUNT) cur_count = data;
    else cur_extrap = data[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender-heavy, then receiver-heavy, then no idling at all
  task automatic set_idling();
    if (items_made < ItemTarget / 3) begin
      send_idle_pct = 33;
      recv_idle_pct = 68;
    end else if (items_made < 2 * ItemTarget / 3) begin
      send_idle_pct = 68;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // fills slots 0..n-1; strictly increasing x unless noisy
  task automatic load_table(input int n, input bit noisy);
    longint step_max;
    longint room;
    longint xv;
    longint yv;
    if (noisy) begin
      for (int k = 0; k < n; k++) begin
        // repeated x now and then gives zero-width segments
        if (k > 0 && $urandom_range(4) == 0) push_load(k[SlotW-1:0], plan_x[k-1], $urandom);
        else push_load(k[SlotW-1:0], $urandom, $urandom);
      end
    end else begin
      case ($urandom_range(2))
        0:       step_max = 256;
        1:       step_max = 64'd1 << 18;
        default: step_max = Span32 / n;
      endcase
      room = Span32 - n * step_max;
      xv   = longint'(S32Min) + longint'($urandom) % (room + 1);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(1)) yv = longint'($urandom_range(2097152)) - 1048576;
        else yv = longint'($urandom);
        push_load(k[SlotW-1:0], xv[DataW-1:0], yv[DataW-1:0]);
        xv += 1 + longint'($urandom) % step_max;
      end
    end
  endtask

  // query abscissa near, at, between or beyond the breakpoints in use
  function automatic logic signed [DataW-1:0] pick_x(input int n);
    longint lo;
    longint hi;
    longint v;
    int     k;
    int     sel;
    lo  = plan_x[0];
    hi  = plan_x[n-1];
    k   = $urandom_range(n - 1);
    sel = $urandom_range(99);
    if (lo > hi) begin
      v  = lo;
      lo = hi;
      hi = v;
    end
    if (sel < 15)      v = plan_x[k];
    else if (sel < 25) v = longint'(plan_x[k]) + ($urandom_range(1) ? 1 : -1);
    else if (sel < 70) v = lo + longint'($urandom) % (hi - lo + 1);
    else if (sel < 80) v = lo - longint'($urandom_range(524288));
    else if (sel < 90) v = hi + longint'($urandom_range(524288));
    else if (sel < 95) v = $urandom_range(1) ? longint'(S32Max) : longint'(S32Min);
    else               v = longint'(int'($urandom));
    if (v > longint'(S32Max)) v = S32Max;
    if (v < longint'(S32Min)) v = S32Min;
    return v[DataW-1:0];
  endfunction

  // queries with a few stray loads mixed in
  task automatic query_burst(input int n, input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 8) push_load(6'($urandom), $urandom, $urandom);
      push_query(pick_x(n));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                  p;
    int                  code;
    int                  n;
    logic [CfgDataW-1:0] cfg_word;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: two points, end values held outside the table
    push_load(6'd0, -32'sd65536, -32'sd196608);
    push_load(6'd1, 32'sd65536, 32'sd327680);
    push_query(S32Min);
    push_query(-32'sd65536);
    push_query(32'sd0);
    push_query(32'sd32768);
    push_query(32'sd65536);
    push_query(S32Max);

    // count below two, extrapolation on, steep segment that saturates both ways
    settle();
    write_cfg(CFG_POINT_COUNT, 7'd0);
    write_cfg(CFG_EXTRAPOLATE, 7'h7f);
    push_load(6'd0, 32'sd0, S32Min);
    push_load(6'd1, 32'sd1, S32Max);
    push_load(6'd62, S32Min, S32Min);
    push_load(6'd63, S32Max, S32Max);
    push_query(S32Max);
    push_query(S32Min);
    push_query(32'sd0);
    push_query(32'sd1);

    // zero-width first segment
    settle();
    write_cfg(CFG_POINT_COUNT, 7'd3);
    write_cfg(CFG_EXTRAPOLATE, 7'd0);
    push_load(6'd0, 32'sd0, 32'sd100);
    push_load(6'd1, 32'sd0, 32'sd200);
    push_load(6'd2, 32'sd65536, 32'sd300);
    push_query(32'sd0);
    push_query(-32'sd5);
    push_query(32'sd40000);

    // random phases: new settings, a fresh table, then queries
    p = 0;
    while (items_made < ItemTarget) begin
      settle();
      set_idling();
      case (p)
        0: code = 2;
        1: code = 64;
        2: code = 1;
        3: code = 127;
        4: code = 65;
        default: code = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(2, 16);
      endcase
      n = code;
      if (n < 2) n = 2;
      if (n > MaxPts) n = MaxPts;
      write_cfg(CFG_POINT_COUNT, code[CfgDataW-1:0]);
      cfg_word = {6'($urandom), 1'($urandom)};
      write_cfg(CFG_EXTRAPOLATE, cfg_word);
      load_table(n, p % 4 == 3);
      query_burst(n, $urandom_range(30, 90));
      p++;
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: piecewise_linear_interpolator.f
hdl/pli_pkg.sv
hdl/piecewise_linear_interpolator.sv
hdl/pli_checker.sv
test/tb_piecewise_linear_interpolator.sv
